// ===== sv/ilt_pkg.sv =====
// ilt_pkg: widths, codes, structs, log2 mantissa table and helper functions
// for the intensity log transform; no dependencies, used by every ilt module
package ilt_pkg;

    // pixel and reference formats
    localparam int PIXEL_BITS     = 16;
    localparam int REF_BITS       = 40;
    localparam int REF_FRAC       = 16;
    localparam int LOG_FRAC       = 16;
    localparam int LOG_TABLE_BITS = 10;
    localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
    localparam int OUT_FRAC_BITS  = 10;
    localparam int OUT_BITS       = 16;

    // reference can be ref_intensity times the frame maximum
    localparam int REF_PROD_BITS = REF_BITS + PIXEL_BITS;
    localparam int POS_BITS      = $clog2(REF_PROD_BITS);
    localparam int LOG_BITS      = POS_BITS + LOG_FRAC;
    localparam int DIFF_BITS     = LOG_BITS + 1;

    // ln 2 in Q.16
    localparam int LN2_BITS = 17;
    localparam logic signed [LN2_BITS-1:0] LN2_Q16 = 45426;

    localparam int PROD_BITS   = DIFF_BITS + LN2_BITS;
    localparam int ROUND_SHIFT = 2 * LOG_FRAC - OUT_FRAC_BITS;
    localparam int RND_BITS    = PROD_BITS - ROUND_SHIFT;
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (ROUND_SHIFT - 1);

    localparam logic [RND_BITS-1:0] NEG_LIMIT = RND_BITS'(1) << (OUT_BITS - 1);
    localparam logic [RND_BITS-1:0] POS_LIMIT = NEG_LIMIT - RND_BITS'(1);
    localparam logic signed [OUT_BITS-1:0] SAT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] SAT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // configuration port
    localparam int CFG_DATA_BITS = 64;
    localparam int PADDR_BITS    = 5;
    localparam int CFG_SEL_LSB   = 3;
    localparam int CFG_SEL_BITS  = PADDR_BITS - CFG_SEL_LSB;

    typedef logic [CFG_SEL_BITS-1:0] cfg_sel_t;
    localparam cfg_sel_t CFG_NORMALIZE = 2'd0;
    localparam cfg_sel_t CFG_USE_MAX   = 2'd1;
    localparam cfg_sel_t CFG_REF       = 2'd2;

    localparam logic [REF_BITS-1:0] REF_RESET = REF_BITS'(65536);

    typedef struct packed {
        logic                normalize_mode;
        logic                use_max_as_ref;
        logic [REF_BITS-1:0] ref_intensity;
    } ilt_cfg_t;

    // statistics seen by a transform beat
    typedef struct packed {
        logic [PIXEL_BITS-1:0] frame_max;
        logic [PIXEL_BITS-1:0] operand;
    } ilt_stats_t;

    typedef logic [LOG_FRAC-1:0] log_table_t [LOG_TABLE_SIZE];

    // fraction bits of log2(1 + k/2^n) by truncated repeated squaring
    function automatic log_table_t build_log_table();
        log_table_t          t;
        logic [63:0]         mant;
        logic [LOG_FRAC-1:0] bits;
        for (int k = 0; k < LOG_TABLE_SIZE; k++) begin
            mant = 64'(LOG_TABLE_SIZE + k) << (31 - LOG_TABLE_BITS);
            bits = '0;
            for (int i = 0; i < LOG_FRAC; i++) begin
                mant = (mant * mant) >> 31;
                bits = {bits[LOG_FRAC-2:0], 1'b0};
                if (mant >= 64'h1_0000_0000) begin
                    bits[0] = 1'b1;
                    mant = mant >> 1;
                end
            end
            t[k] = bits;
        end
        return t;
    endfunction

    localparam log_table_t LOG_TABLE = build_log_table();

    // position of the leading one, zero for a zero word
    function automatic logic [POS_BITS-1:0] lead_one(input logic [REF_PROD_BITS-1:0] v);
        logic [POS_BITS-1:0] pos;
        pos = '0;
        for (int i = 0; i < REF_PROD_BITS; i++) begin
            if (v[i]) pos = POS_BITS'(i);
        end
        return pos;
    endfunction

    // mantissa bits just below the leading one, zero filled
    function automatic logic [LOG_TABLE_BITS-1:0] mant_index(
        input logic [REF_PROD_BITS-1:0] v,
        input logic [POS_BITS-1:0]      p
    );
        logic [REF_PROD_BITS+LOG_TABLE_BITS-1:0] ext;
        ext = {v, {LOG_TABLE_BITS{1'b0}}} >> p;
        return ext[LOG_TABLE_BITS-1:0];
    endfunction

endpackage

// ===== sv/ilt_cfg_regs.sv =====
// ilt_cfg_regs: apb register file for normalize_mode, use_max_as_ref, ref_intensity
// depends on ilt_pkg
module ilt_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ilt_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [ilt_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [ilt_pkg::CFG_DATA_BITS-1:0] prdata,
    output ilt_pkg::ilt_cfg_t                 cfg
);
    import ilt_pkg::*;

    logic     normalize_reg;
    logic     use_max_reg;
    logic [REF_BITS-1:0] ref_reg;
    logic     wr_en;
    cfg_sel_t sel;

    assign wr_en = psel && penable && pwrite;
    assign sel   = paddr[PADDR_BITS-1:CFG_SEL_LSB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normalize_reg <= 1'b0;
            use_max_reg   <= 1'b0;
            ref_reg       <= REF_RESET;
        end else if (wr_en) begin
            unique case (sel)
                CFG_NORMALIZE: normalize_reg <= pwdata[0];
                CFG_USE_MAX:   use_max_reg   <= pwdata[0];
                CFG_REF:       ref_reg       <= pwdata[REF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            CFG_NORMALIZE: prdata = CFG_DATA_BITS'(normalize_reg);
            CFG_USE_MAX:   prdata = CFG_DATA_BITS'(use_max_reg);
            CFG_REF:       prdata = CFG_DATA_BITS'(ref_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.normalize_mode = normalize_reg;
    assign cfg.use_max_as_ref = use_max_reg;
    assign cfg.ref_intensity  = ref_reg;

endmodule

// ===== sv/ilt_stats.sv =====
// ilt_stats: frame maximum and smallest positive pixel from gather beats,
// operand choice for transform beats; depends on ilt_pkg
module ilt_stats (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           gather_en,
    input  logic                           frame_start,
    input  logic [ilt_pkg::PIXEL_BITS-1:0] pixel,
    output ilt_pkg::ilt_stats_t            stats
);
    import ilt_pkg::*;

    logic [PIXEL_BITS-1:0] max_reg, max_next;
    logic [PIXEL_BITS-1:0] min_reg, min_next;
    logic                  seen_reg, seen_next;
    logic [PIXEL_BITS-1:0] base_max, base_min;
    logic                  base_seen;

    always_comb begin
        base_max  = frame_start ? '0 : max_reg;
        base_min  = frame_start ? '0 : min_reg;
        base_seen = frame_start ? 1'b0 : seen_reg;
        max_next  = (pixel > base_max) ? pixel : base_max;
        min_next  = base_min;
        seen_next = base_seen;
        if (pixel != '0 && (!base_seen || pixel < base_min)) begin
            min_next  = pixel;
            seen_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg  <= '0;
            min_reg  <= '0;
            seen_reg <= 1'b0;
        end else if (gather_en) begin
            max_reg  <= max_next;
            min_reg  <= min_next;
            seen_reg <= seen_next;
        end
    end

    // zero pixel falls back to the smallest positive one
    assign stats.frame_max = max_reg;
    assign stats.operand   = (pixel != '0) ? pixel : (seen_reg ? min_reg : '0);

    a_min_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> min_reg == '0)
        else $error("smallest positive held without a positive pixel");

    a_min_order: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (min_reg != '0 && min_reg <= max_reg))
        else $error("smallest positive out of range of the maximum");

endmodule

// ===== sv/ilt_log_pipe.sv =====
// ilt_log_pipe: reference select, log2 by leading one and table, ln 2 scaling,
// rounding and saturation, ending in the output register; depends on ilt_pkg
module ilt_log_pipe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ilt_pkg::ilt_cfg_t              cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ilt_pkg::PIXEL_BITS-1:0] in_operand,
    input  logic [ilt_pkg::PIXEL_BITS-1:0] in_frame_max,
    input  logic                           in_last,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ilt_pkg::OUT_BITS-1:0]   m_tdata,
    output logic                           m_tlast
);
    import ilt_pkg::*;

    // stage 1: captured operand and maximum
    logic                     s1_valid_reg;
    logic [PIXEL_BITS-1:0]    s1_x_reg, s1_max_reg;
    logic                     s1_last_reg;
    // stage 2: reference
    logic                     s2_valid_reg;
    logic [REF_PROD_BITS-1:0] s2_ref_reg, s2_ref_next;
    logic [PIXEL_BITS-1:0]    s2_x_reg;
    logic                     s2_last_reg;
    // stage 3: leading one and table index
    logic                     s3_valid_reg;
    logic [POS_BITS-1:0]      s3_pr_reg, s3_px_reg;
    logic [LOG_TABLE_BITS-1:0] s3_ir_reg, s3_ix_reg;
    logic                     s3_ref_zero_reg, s3_x_zero_reg, s3_last_reg;
    logic [POS_BITS-1:0]      pr_next, px_raw;
    // stage 4: log difference
    logic                     s4_valid_reg;
    logic signed [DIFF_BITS-1:0] s4_diff_reg, s4_diff_next;
    logic                     s4_ref_zero_reg, s4_x_zero_reg, s4_last_reg;
    // stage 5: scaled by ln 2
    logic                     s5_valid_reg;
    logic signed [PROD_BITS-1:0] s5_prod_reg, s5_prod_next;
    logic                     s5_ref_zero_reg, s5_x_zero_reg, s5_last_reg;
    // output register
    logic                     out_valid_reg;
    logic signed [OUT_BITS-1:0] out_value_reg, out_value_next;
    logic                     out_last_reg;

    logic out_ready, s5_ready, s4_ready, s3_ready, s2_ready, s1_ready;
    logic [PROD_BITS-1:0] mag, rsum;
    logic [RND_BITS-1:0]  rnd;

    assign out_ready = !out_valid_reg || m_tready;
    assign s5_ready  = !s5_valid_reg || out_ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready)  s1_valid_reg  <= in_valid;
            if (s2_ready)  s2_valid_reg  <= s1_valid_reg;
            if (s3_ready)  s3_valid_reg  <= s2_valid_reg;
            if (s4_ready)  s4_valid_reg  <= s3_valid_reg;
            if (s5_ready)  s5_valid_reg  <= s4_valid_reg;
            if (out_ready) out_valid_reg <= s5_valid_reg;
        end
    end

    // reference in Q.16
    always_comb begin
        if (cfg.normalize_mode && cfg.use_max_as_ref)
            s2_ref_next = REF_PROD_BITS'(s1_max_reg) << REF_FRAC;
        else if (cfg.normalize_mode)
            s2_ref_next = REF_PROD_BITS'(cfg.ref_intensity) * REF_PROD_BITS'(s1_max_reg);
        else
            s2_ref_next = REF_PROD_BITS'(cfg.ref_intensity);
    end

    assign pr_next = lead_one(s2_ref_reg);
    assign px_raw  = lead_one(REF_PROD_BITS'(s2_x_reg));

    // log2 of the operand is taken on x << 16
    assign s4_diff_next = $signed({1'b0, s3_pr_reg, LOG_TABLE[s3_ir_reg]})
                        - $signed({1'b0, s3_px_reg, LOG_TABLE[s3_ix_reg]});

    assign s5_prod_next = PROD_BITS'(s4_diff_reg) * PROD_BITS'(LN2_Q16);

    // round half away from zero, then saturate
    always_comb begin
        mag  = s5_prod_reg[PROD_BITS-1] ? PROD_BITS'(-s5_prod_reg) : PROD_BITS'(s5_prod_reg);
        rsum = mag + ROUND_HALF;
        rnd  = rsum[PROD_BITS-1:ROUND_SHIFT];
        if (s5_ref_zero_reg)
            out_value_next = SAT_MIN;
        else if (s5_x_zero_reg)
            out_value_next = SAT_MAX;
        else if (s5_prod_reg[PROD_BITS-1])
            out_value_next = (rnd >= NEG_LIMIT) ? SAT_MIN : -$signed(rnd[OUT_BITS-1:0]);
        else
            out_value_next = (rnd >= POS_LIMIT) ? SAT_MAX : $signed(rnd[OUT_BITS-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_x_reg    <= in_operand;
            s1_max_reg  <= in_frame_max;
            s1_last_reg <= in_last;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_ref_reg  <= s2_ref_next;
            s2_x_reg    <= s1_x_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_pr_reg       <= pr_next;
            s3_ir_reg       <= mant_index(s2_ref_reg, pr_next);
            s3_px_reg       <= px_raw + POS_BITS'(REF_FRAC);
            s3_ix_reg       <= mant_index(REF_PROD_BITS'(s2_x_reg), px_raw);
            s3_ref_zero_reg <= (s2_ref_reg == '0);
            s3_x_zero_reg   <= (s2_x_reg == '0);
            s3_last_reg     <= s2_last_reg;
        end
        if (s4_ready && s3_valid_reg) begin
            s4_diff_reg     <= s4_diff_next;
            s4_ref_zero_reg <= s3_ref_zero_reg;
            s4_x_zero_reg   <= s3_x_zero_reg;
            s4_last_reg     <= s3_last_reg;
        end
        if (s5_ready && s4_valid_reg) begin
            s5_prod_reg     <= s5_prod_next;
            s5_ref_zero_reg <= s4_ref_zero_reg;
            s5_x_zero_reg   <= s4_x_zero_reg;
            s5_last_reg     <= s4_last_reg;
        end
        if (out_ready && s5_valid_reg) begin
            out_value_reg <= out_value_next;
            out_last_reg  <= s5_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_x_reg)))
        else $error("stage 1 lost its beat while stalled");

    a_ref_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_ready && s5_valid_reg && s5_ref_zero_reg)
        |=> (out_valid_reg && out_value_reg == SAT_MIN))
        else $error("zero reference did not saturate low");

    a_x_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_ready && s5_valid_reg && !s5_ref_zero_reg && s5_x_zero_reg)
        |=> (out_valid_reg && out_value_reg == SAT_MAX))
        else $error("zero operand did not saturate high");

endmodule

// ===== sv/intensity_log_transform.sv =====
// intensity_log_transform: top level of the x-ray intensity log transform
// depends on ilt_pkg, ilt_cfg_regs, ilt_stats, ilt_log_pipe
//
// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       pixel, op + frame_start, frame_end
// m_        out  m_tvalid / m_tready       log_value, last
// apb       in   psel / penable / pready   normalize_mode, use_max_as_ref, ref_intensity
//
// one beat per cycle in both passes while s_tready is high; a gather beat
// updates the statistics at its accept edge and gives no result
// a transform beat passes the registered stages (capture, reference, leading
// one, table and difference, ln 2 multiply, round and saturate into the
// output register) before its result is valid
// a stall on m_ backs up stage by stage, so bubbles are filled before
// s_tready drops; reset clears statistics, registers and all stage valids
module intensity_log_transform (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] pixel
    input  logic [1:0]                        s_tuser,   // [0] op, [1] frame_start
    input  logic                              s_tlast,   // frame_end
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] log_value
    output logic                              m_tlast,   // last
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ilt_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [ilt_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [ilt_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import ilt_pkg::*;

    ilt_cfg_t   cfg;
    ilt_stats_t stats;
    logic       in_ready;
    logic       s_beat;
    logic       gather_en;
    logic       transform_en;

    // a beat is taken whenever the first stage has room, whatever its pass
    assign s_tready     = in_ready;
    assign s_beat       = s_tvalid && in_ready;
    assign gather_en    = s_beat && !s_tuser[0];
    assign transform_en = s_beat && s_tuser[0];
    assign pready       = 1'b1;

    ilt_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // gather pass statistics, and the operand a transform beat will use
    ilt_stats u_stats (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .gather_en   (gather_en),
        .frame_start (s_tuser[1]),
        .pixel       (s_tdata[PIXEL_BITS-1:0]),
        .stats       (stats)
    );

    // transform pass datapath with its output register
    ilt_log_pipe u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (transform_en),
        .in_ready     (in_ready),
        .in_operand   (stats.operand),
        .in_frame_max (stats.frame_max),
        .in_last      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

// ===== dv/intensity_log_transform_tb.sv =====
// intensity_log_transform_tb: self-checking testbench for the intensity log transform
// drives pixel beats and apb register writes, predicts every result and checks it
// depends on ilt_pkg and intensity_log_transform
module intensity_log_transform_tb;

    localparam int ADDR_W      = ilt_pkg::PADDR_BITS;
    localparam int TABLE_BITS  = 10;
    localparam int ROUND_SH    = 22;                 // q.32 product down to q.10
    localparam longint LN2_Q16 = 45426;
    localparam logic signed [15:0] LOG_MIN = 16'sh8000;
    localparam logic signed [15:0] LOG_MAX = 16'sh7fff;
    // the limit covers the slowest run plus the long sink hold
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic {OP_GATHER = 1'b0, OP_TRANSFORM = 1'b1} pass_op_t;

    typedef struct packed {
        pass_op_t    op;
        logic        frame_start;
        logic        frame_end;
        logic [15:0] pixel;
    } pixel_beat_t;

    typedef struct packed {
        logic signed [15:0] log_value;
        logic               last;
    } log_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [15:0] pixel
    logic [1:0]  s_tuser  = '0;     // [0] op, [1] frame_start
    logic        s_tlast  = 1'b0;   // frame_end

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] log_value
    logic        m_tlast;           // last

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [63:0]       pwdata  = '0;
    logic [63:0]       prdata;
    logic              pready;

    intensity_log_transform i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state: register copies, gathered statistics, log2 fraction table
    logic        cfg_normalize = 1'b0;
    logic        cfg_use_max   = 1'b0;
    logic [39:0] cfg_ref       = 40'd65536;
    logic [15:0] stat_max      = '0;
    logic [15:0] stat_min_pos  = '0;
    logic        stat_pos_seen = 1'b0;
    logic [15:0] log2_frac [1 << TABLE_BITS];

    pixel_beat_t pending_beats [$];
    log_result_t expected_logs [$];

    int   beats_queued   = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   hold_left      = 0;
    logic sink_hold_req  = 1'b0;
    logic sink_hold_used = 1'b0;
    logic no_gaps        = 1'b0;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // log2 in q.16: leading one position plus table of the next mantissa bits
    function automatic longint log2_q16(input logic [63:0] v);
        int          lead;
        logic [63:0] aligned;
        lead = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) lead = i;
        if (lead >= TABLE_BITS)
            aligned = v >> (lead - TABLE_BITS);
        else
            aligned = v << (TABLE_BITS - lead);
        return longint'(lead) * 65536 + longint'(log2_frac[aligned[TABLE_BITS-1:0]]);
    endfunction

    // -ln(x/ref) in q5.10, rounded half away from zero and saturated
    function automatic logic signed [15:0] predict_log_value(input logic [15:0] pixel);
        logic [63:0] ref_val;
        logic [63:0] x;
        longint      diff;
        longint      prod;
        longint      mag;
        longint      rnd;
        if (cfg_normalize && cfg_use_max)
            ref_val = 64'(stat_max) << 16;
        else if (cfg_normalize)
            ref_val = 64'(cfg_ref) * 64'(stat_max);
        else
            ref_val = 64'(cfg_ref);
        // zero pixel falls back to the smallest positive one
        x = 64'(pixel != 0 ? pixel : (stat_pos_seen ? stat_min_pos : 16'd0)) << 16;
        if (ref_val == 0)
            return LOG_MIN;
        if (x == 0)
            return LOG_MAX;
        diff = log2_q16(ref_val) - log2_q16(x);
        prod = diff * LN2_Q16;
        mag  = prod < 0 ? -prod : prod;
        rnd  = (mag + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (prod < 0)
            return rnd >= 32768 ? LOG_MIN : 16'(-rnd);
        return rnd >= 32767 ? LOG_MAX : 16'(rnd);
    endfunction

    // one accepted beat: gather updates statistics, transform expects a result
    task automatic apply_beat(input pixel_beat_t b);
        log_result_t res;
        if (b.op == OP_GATHER) begin
            if (b.frame_start) begin
                stat_max      = '0;
                stat_min_pos  = '0;
                stat_pos_seen = 1'b0;
            end
            if (b.pixel > stat_max)
                stat_max = b.pixel;
            if (b.pixel != 0 && (!stat_pos_seen || b.pixel < stat_min_pos)) begin
                stat_min_pos  = b.pixel;
                stat_pos_seen = 1'b1;
            end
        end else begin
            res.log_value = predict_log_value(b.pixel);
            res.last      = b.frame_end;
            expected_logs.push_back(res);
        end
    endtask

    // sender: takes the next pending beat once the current one is accepted
    always @(posedge aclk) begin : drive_beats
        pixel_beat_t cur;
        pixel_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cur.op          = pass_op_t'(s_tuser[0]);
                cur.frame_start = s_tuser[1];
                cur.frame_end   = s_tlast;
                cur.pixel       = s_tdata;
                apply_beat(cur);
            end
            if (!s_tvalid || s_tready) begin
                // a random gap on about 12 in 100 chances unless a gapless stretch runs
                if (pending_beats.size() != 0 && (no_gaps || $urandom_range(99) >= 12)) begin
                    nxt = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.pixel;
                    s_tuser  <= {nxt.frame_start, nxt.op};
                    s_tlast  <= nxt.frame_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long sink hold, counted here so the sender keeps pushing into a full pipe
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (sink_hold_req && !sink_hold_used) begin
            hold_left      <= 400;
            sink_hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: compares each result beat with the oldest expectation
    always @(posedge aclk) begin : check_results
        log_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_logs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d last %0b",
                        $signed(m_tdata), m_tlast));
                end else begin
                    want = expected_logs.pop_front();
                    if (m_tdata !== want.log_value)
                        report_mismatch($sformatf("log_value %0d, expected %0d",
                            $signed(m_tdata), want.log_value));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                            m_tlast, want.last));
                end
            end
            m_tready <= !(hold_left != 0 || (!no_gaps && $urandom_range(99) < 12));
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void push_beat(input pass_op_t op, input logic [15:0] pixel,
                                      input logic fs, input logic fe);
        pixel_beat_t b;
        b.op          = op;
        b.pixel       = pixel;
        b.frame_start = fs;
        b.frame_end   = fe;
        pending_beats.push_back(b);
        beats_queued++;
    endfunction

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(9))
            0, 1:    return 16'd0;
            2, 3:    return 16'($urandom_range(1, 15));
            4:       return 16'hffff;
            5, 6:    return 16'($urandom_range(16'hffff));
            default: return 16'($urandom_range(100, 5000));
        endcase
    endfunction

    // one frame: gather pass then transform pass of the same length
    function automatic void add_frame(input int n);
        logic zero_frame;
        zero_frame = ($urandom_range(19) == 0);
        for (int i = 0; i < n; i++)
            push_beat(OP_GATHER, zero_frame ? 16'd0 : rand_pixel(), i == 0, i == n - 1);
        for (int i = 0; i < n; i++)
            push_beat(OP_TRANSFORM, rand_pixel(), $urandom_range(9) == 0, i == n - 1);
    endfunction

    // stray beats: transform with stale stats, gather with a random frame start
    function automatic void add_noise(input int n);
        for (int i = 0; i < n; i++)
            push_beat(pass_op_t'($urandom_range(1)), 16'($urandom_range(16'hffff)),
                      $urandom_range(7) == 0, 1'($urandom_range(1)));
    endfunction

    function automatic void add_random_beats(input int target);
        int start;
        start = beats_queued;
        while (beats_queued - start < target) begin
            if ($urandom_range(99) < 15)
                add_noise($urandom_range(1, 6));
            else if ($urandom_range(9) == 0)
                add_frame($urandom_range(20, 40));
            else
                add_frame($urandom_range(1, 12));
        end
    endfunction

    task automatic write_reg(input ilt_pkg::cfg_sel_t sel, input logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(sel) << ilt_pkg::CFG_SEL_LSB;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (sel)
            ilt_pkg::CFG_NORMALIZE: cfg_normalize = value[0];
            ilt_pkg::CFG_USE_MAX:   cfg_use_max   = value[0];
            ilt_pkg::CFG_REF:       cfg_ref       = value[39:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic norm, input logic use_max, input logic [63:0] ref_val);
        write_reg(ilt_pkg::CFG_NORMALIZE, 64'(norm));
        write_reg(ilt_pkg::CFG_USE_MAX, 64'(use_max));
        write_reg(ilt_pkg::CFG_REF, ref_val);
    endtask

    // wait until every beat went in and every result came out, then let
    // in-flight gather beats settle before touching the registers
    task automatic drain();
        while (pending_beats.size() != 0 || s_tvalid || expected_logs.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : run_test
        logic [63:0] mant;
        logic [15:0] frac;
        logic [63:0] rand_ref;
        int          phase;

        // log2(1 + k/1024) fraction bits by truncated repeated squaring
        for (int k = 0; k < (1 << TABLE_BITS); k++) begin
            mant = 64'((1 << TABLE_BITS) + k) << (31 - TABLE_BITS);
            frac = '0;
            for (int i = 0; i < 16; i++) begin
                mant = (mant * mant) >> 31;
                frac = {frac[14:0], mant[32]};
                if (mant[32])
                    mant = mant >> 1;
            end
            log2_frac[k] = frac;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: transform before any gather, no positive pixel yet
        push_beat(OP_TRANSFORM, 16'd0, 1'b1, 1'b0);
        push_beat(OP_TRANSFORM, 16'hffff, 1'b0, 1'b0);
        // gather with both extremes, then transform incl. zero pixel
        push_beat(OP_GATHER, 16'd0, 1'b1, 1'b0);
        push_beat(OP_GATHER, 16'd300, 1'b0, 1'b0);
        push_beat(OP_GATHER, 16'hffff, 1'b0, 1'b0);
        push_beat(OP_GATHER, 16'd1, 1'b0, 1'b1);
        push_beat(OP_TRANSFORM, 16'd0, 1'b0, 1'b0);
        push_beat(OP_TRANSFORM, 16'd1, 1'b0, 1'b0);
        push_beat(OP_TRANSFORM, 16'hffff, 1'b0, 1'b0);
        push_beat(OP_TRANSFORM, 16'd300, 1'b1, 1'b0);
        // extra gather beat with frame end set, no frame start
        push_beat(OP_GATHER, 16'd7, 1'b0, 1'b1);
        push_beat(OP_TRANSFORM, 16'd2, 1'b0, 1'b1);
        // all-zero frame: no positive pixel, zero pixel saturates high
        push_beat(OP_GATHER, 16'd0, 1'b1, 1'b0);
        push_beat(OP_GATHER, 16'd0, 1'b0, 1'b1);
        push_beat(OP_TRANSFORM, 16'd0, 1'b0, 1'b0);
        push_beat(OP_TRANSFORM, 16'd5, 1'b0, 1'b1);
        drain();

        // normalize with a zero maximum: zero reference saturates low
        write_reg(ilt_pkg::CFG_NORMALIZE, 64'd1);
        push_beat(OP_TRANSFORM, 16'd0, 1'b0, 1'b0);
        push_beat(OP_TRANSFORM, 16'd9, 1'b0, 1'b1);
        drain();

        // zero ref_intensity without normalize
        write_config(1'b0, 1'b0, 64'd0);
        push_beat(OP_TRANSFORM, 16'd77, 1'b0, 1'b1);
        drain();

        // use-max reference, pixels above the gathered maximum
        write_config(1'b1, 1'b1, 64'd65536);
        push_beat(OP_GATHER, 16'd100, 1'b1, 1'b1);
        push_beat(OP_TRANSFORM, 16'd60000, 1'b0, 1'b0);
        push_beat(OP_TRANSFORM, 16'd0, 1'b0, 1'b0);
        push_beat(OP_TRANSFORM, 16'd100, 1'b0, 1'b1);
        drain();

        // extreme settings with random frames
        write_config(1'b0, 1'b0, 64'd1);
        add_random_beats(40);
        drain();
        write_config(1'b1, 1'b0, 64'hff_ffff_ffff);
        add_random_beats(40);
        drain();
        // use-max without normalize keeps ref_intensity
        write_config(1'b0, 1'b1, 64'hff_ffff_ffff);
        add_random_beats(40);
        drain();

        // random settings until enough beats went through
        phase = 0;
        while (beats_queued < 540) begin
            case ($urandom_range(3))
                0:       rand_ref = 64'($urandom_range(1, 1 << 18));
                1:       rand_ref = {$urandom, $urandom};
                2:       rand_ref = 64'd65536;
                default: rand_ref = 64'hff_ffff_ffff;
            endcase
            write_config(1'($urandom_range(1)), 1'($urandom_range(1)), rand_ref);
            if (phase == 1)
                no_gaps <= 1'b1;
            add_random_beats(60);
            // sink stalls long enough to back the pipe up into s_tready
            if (phase == 0)
                sink_hold_req <= 1'b1;
            drain();
            no_gaps <= 1'b0;
            phase++;
        end

        repeat (12) @(posedge aclk);
        if (expected_logs.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_logs.size()));
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
